// ===== sv/rom_font_glyph_trim_and_measure_defines.svh =====
// Assertion macros used by the top level file to check this block.
// Each macro samples on the rising edge of clk and is disabled while rst is high.
`ifndef ROM_FONT_GLYPH_TRIM_AND_MEASURE_DEFINES_SVH
`define ROM_FONT_GLYPH_TRIM_AND_MEASURE_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define FGM_ASSERT_SAME(label, cond, conseq, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (conseq)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define FGM_ASSERT_NEXT(label, cond, conseq, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (conseq)) \
    else $error(msg);

`endif

// ===== sv/fgm_pkg.sv =====
package fgm_pkg;

  // Font geometry.
  localparam int GLYPH_COUNT = 96;
  localparam int GLYPH_ROWS  = 8;
  localparam int GLYPH_BYTES = 16;
  localparam logic [7:0] FIRST_CHAR = 8'h20;

  // Derived widths.
  localparam int GI_W      = (GLYPH_COUNT > 1) ? $clog2(GLYPH_COUNT) : 1;
  localparam int ROW_SEL_W = $clog2(GLYPH_ROWS);
  localparam int ROW_AW    = GI_W + ROW_SEL_W;
  localparam int ROW_DEPTH = GLYPH_COUNT * GLYPH_ROWS;
  localparam int K_W       = $clog2(GLYPH_BYTES);
  localparam int POS_W     = 17;
  localparam int REL_GI_W  = POS_W - K_W;
  localparam logic [POS_W-1:0] POS_MAX = '1;

  // Operation codes.
  localparam logic [1:0] OP_START   = 2'd0;
  localparam logic [1:0] OP_LOAD    = 2'd1;
  localparam logic [1:0] OP_PIXEL   = 2'd2;
  localparam logic [1:0] OP_MEASURE = 2'd3;

  // Configuration register indexes.
  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] CFG_ROM_OFFSET    = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SPACE_ADVANCE = 1'd1;
  localparam logic [3:0] SPACE_ADVANCE_RESET = 4'd4;

  // Input item.
  typedef struct packed {
    logic [1:0] operation;
    logic [7:0] data_byte;
    logic [7:0] char_code;
    logic [3:0] x_pos;
    logic [3:0] y_pos;
    logic       new_text;
  } fgm_in_t;

  // Result item.
  typedef struct packed {
    logic        pixel;
    logic [3:0]  glyph_width;
    logic [3:0]  advance;
    logic [15:0] text_width;
    logic        ready_res;
  } fgm_out_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic capture;
    logic exec;
    logic trim;
    logic query;
  } fgm_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic [1:0] op;
    logic       glyph_done;
    logic       trim_last;
  } fgm_status_t;

endpackage

// ===== sv/fgm_ctrl.sv =====
module fgm_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  fgm_pkg::fgm_status_t status,
  output fgm_pkg::fgm_cmd_t   cmd,
  output logic                busy,
  output logic                done
);

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_EXEC  = 5'b00010,
    S_TRIM  = 5'b00100,
    S_QUERY = 5'b01000,
    S_RESP  = 5'b10000
  } fgm_state_t;

  fgm_state_t state, state_next;

  // Next state selection.
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (start) state_next = S_EXEC;
      end
      S_EXEC: begin
        if (status.op == fgm_pkg::OP_PIXEL || status.op == fgm_pkg::OP_MEASURE) begin
          state_next = S_QUERY;
        end else if (status.glyph_done) begin
          state_next = S_TRIM;
        end else begin
          state_next = S_RESP;
        end
      end
      S_TRIM: begin
        if (status.trim_last) state_next = S_RESP;
      end
      S_QUERY: state_next = S_RESP;
      S_RESP:  state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Commands and handshake outputs are decoded from the state; capture also needs start.
  always_comb begin
    cmd.capture = (state == S_IDLE) && start;
    cmd.exec    = (state == S_EXEC);
    cmd.trim    = (state == S_TRIM);
    cmd.query   = (state == S_QUERY);
  end

  assign busy = (state != S_IDLE);
  assign done = (state == S_RESP);

endmodule

// ===== sv/fgm_datapath.sv =====
module fgm_datapath (
  input  logic                 clk,
  input  logic                 rst,
  input  fgm_pkg::fgm_in_t     cmd_in,
  input  fgm_pkg::fgm_cmd_t    cmd,
  input  logic                 cfg_wr,
  input  logic [fgm_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [15:0]          cfg_data,
  output fgm_pkg::fgm_status_t status,
  output fgm_pkg::fgm_out_t    result
);

  // Configuration registers.
  logic [15:0] rom_offset;
  logic [3:0]  space_advance;

  // Loader state.
  fgm_pkg::fgm_in_t cmd_q;
  logic [fgm_pkg::POS_W-1:0] byte_position;
  logic [7:0] plane_hold;
  logic [7:0] column_mask;
  logic [7:0] staging_rows [fgm_pkg::GLYPH_ROWS];
  logic       font_ready;
  logic [15:0] text_total;
  logic [fgm_pkg::ROW_SEL_W-1:0] trim_row;
  logic [fgm_pkg::GI_W-1:0] trim_gi;

  // Result and memory read registers.
  logic       pix_q;
  logic [3:0] w_q;
  logic [3:0] adv_q;
  logic [7:0] rd_row;
  logic [3:0] rd_w;

  // Glyph memories.
  logic [7:0] row_store   [fgm_pkg::ROW_DEPTH];
  logic [3:0] width_store [fgm_pkg::GLYPH_COUNT];

  // Position decode for a load byte.
  logic [fgm_pkg::POS_W-1:0] rel;
  logic [fgm_pkg::REL_GI_W-1:0] rel_gi;
  logic [fgm_pkg::K_W-1:0] rel_k;
  logic       load_store;
  logic [7:0] row_val;

  assign rel    = byte_position - fgm_pkg::POS_W'(rom_offset);
  assign rel_gi = rel[fgm_pkg::POS_W-1:fgm_pkg::K_W];
  assign rel_k  = rel[fgm_pkg::K_W-1:0];
  assign row_val = plane_hold | cmd_q.data_byte;
  assign load_store = (cmd_q.operation == fgm_pkg::OP_LOAD) && !font_ready &&
                      (byte_position >= fgm_pkg::POS_W'(rom_offset)) &&
                      (rel_gi < fgm_pkg::REL_GI_W'(fgm_pkg::GLYPH_COUNT));

  // Leftmost and rightmost set columns of the glyph being finished.
  logic [2:0] col_lo, col_hi;
  logic       col_found;
  logic [3:0] trim_width;

  always_comb begin
    col_lo    = 3'd0;
    col_hi    = 3'd0;
    col_found = 1'b0;
    for (int c = 0; c < 8; c++) begin
      if (column_mask[7 - c]) begin
        if (!col_found) col_lo = 3'(c);
        col_found = 1'b1;
        col_hi    = 3'(c);
      end
    end
    trim_width = col_found ? ({1'b0, col_hi} - {1'b0, col_lo} + 4'd1) : 4'd0;
  end

  logic trim_last;
  logic [fgm_pkg::ROW_AW-1:0] wr_addr;
  logic [7:0] trimmed_row;

  // A blank glyph stores empty rows whatever is left in the staging rows.
  assign trim_last   = (trim_row == fgm_pkg::ROW_SEL_W'(fgm_pkg::GLYPH_ROWS - 1));
  assign wr_addr     = {trim_gi, trim_row};
  assign trimmed_row = col_found ? (staging_rows[trim_row] << col_lo) : 8'd0;

  // Query addressing from the captured character code.
  logic [7:0] char_off;
  logic [fgm_pkg::GI_W-1:0] q_gi;
  logic [fgm_pkg::ROW_AW-1:0] rd_addr;

  assign char_off = cmd_q.char_code - fgm_pkg::FIRST_CHAR;
  assign q_gi     = char_off[fgm_pkg::GI_W-1:0];
  assign rd_addr  = {q_gi, cmd_q.y_pos[fgm_pkg::ROW_SEL_W-1:0]};

  // Query result from the registered memory data.
  logic [8:0]  char_ext;
  logic        char_valid;
  logic        q_pix;
  logic [3:0]  q_w;
  logic [3:0]  q_adv;
  logic [16:0] q_sum;

  always_comb begin
    char_ext   = {1'b0, cmd_q.char_code};
    char_valid = font_ready && (char_ext >= 9'(fgm_pkg::FIRST_CHAR)) &&
                 (char_ext < 9'(fgm_pkg::FIRST_CHAR + fgm_pkg::GLYPH_COUNT));
    q_w   = char_valid ? rd_w : 4'd0;
    q_pix = char_valid && !cmd_q.x_pos[3] && !cmd_q.y_pos[3] &&
            rd_row[3'd7 - cmd_q.x_pos[2:0]];
    q_adv = (q_w == 4'd0) ? space_advance : q_w + 4'd1;
    q_sum = (cmd_q.new_text ? 17'd0 : {1'b0, text_total}) + 17'(q_adv);
  end

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      rom_offset    <= '0;
      space_advance <= fgm_pkg::SPACE_ADVANCE_RESET;
    end else if (cfg_wr) begin
      case (cfg_index)
        fgm_pkg::CFG_ROM_OFFSET:    rom_offset    <= cfg_data;
        fgm_pkg::CFG_SPACE_ADVANCE: space_advance <= cfg_data[3:0];
        default: ;
      endcase
    end
  end

  // Captured transaction.
  always_ff @(posedge clk) begin
    if (cmd.capture) cmd_q <= cmd_in;
  end

  // Loader control state and running text width.
  always_ff @(posedge clk) begin
    if (rst) begin
      byte_position <= '0;
      plane_hold    <= '0;
      column_mask   <= '0;
      font_ready    <= 1'b0;
      text_total    <= '0;
      trim_row      <= '0;
    end else begin
      if (cmd.exec) begin
        case (cmd_q.operation)
          fgm_pkg::OP_START: begin
            byte_position <= '0;
            plane_hold    <= '0;
            column_mask   <= '0;
            font_ready    <= 1'b0;
          end
          fgm_pkg::OP_LOAD: begin
            if (!font_ready) begin
              if (load_store) begin
                if (!rel_k[0]) begin
                  plane_hold <= cmd_q.data_byte;
                end else begin
                  column_mask <= column_mask | row_val;
                end
              end
              if (byte_position != fgm_pkg::POS_MAX) byte_position <= byte_position + 1'b1;
            end
          end
          default: ;
        endcase
      end
      if (cmd.trim) begin
        trim_row <= trim_row + 1'b1;
        if (trim_last) begin
          column_mask <= '0;
          if (trim_gi == fgm_pkg::GI_W'(fgm_pkg::GLYPH_COUNT - 1)) font_ready <= 1'b1;
        end
      end
      if (cmd.query && cmd_q.operation == fgm_pkg::OP_MEASURE) begin
        text_total <= q_sum[16] ? 16'hFFFF : q_sum[15:0];
      end
    end
  end

  // Staging rows, glyph index and result payload registers.
  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      pix_q <= 1'b0;
      w_q   <= 4'd0;
      adv_q <= 4'd0;
      if (load_store && rel_k[0]) begin
        staging_rows[rel_k[fgm_pkg::K_W-1:1]] <= row_val;
      end
      trim_gi <= rel[fgm_pkg::K_W + fgm_pkg::GI_W - 1:fgm_pkg::K_W];
    end
    if (cmd.query) begin
      pix_q <= q_pix;
      w_q   <= q_w;
      adv_q <= q_adv;
    end
  end

  // Glyph memories: one write port each, registered reads.
  always_ff @(posedge clk) begin
    if (cmd.trim) row_store[wr_addr] <= trimmed_row;
    if (cmd.trim && trim_last) width_store[trim_gi] <= trim_width;
    rd_row <= row_store[rd_addr];
    rd_w   <= width_store[q_gi];
  end

  // Status and result.
  always_comb begin
    status.op         = cmd_q.operation;
    status.glyph_done = load_store && (rel_k == fgm_pkg::K_W'(fgm_pkg::GLYPH_BYTES - 1));
    status.trim_last  = trim_last;
  end

  always_comb begin
    result.pixel       = pix_q;
    result.glyph_width = w_q;
    result.advance     = adv_q;
    result.text_width  = text_total;
    result.ready_res   = font_ready;
  end

endmodule

// ===== sv/rom_font_glyph_trim_and_measure.sv =====
// Font glyph trimmer and text measurer.
// Commands arrive on cmd and are taken at a clock edge where start is high and
// busy is low. Each transaction gives one result on result, valid for the single
// cycle in which done is high; the receiver cannot stall, so it must take it then.
// Start commands and plain load bytes go from the execute state straight to the
// result state, in which done is high; a new command can be taken in the cycle
// after it. A load byte that completes a glyph adds a trim pass before the result,
// which writes the glyph rows into the row memory one row after another.
// Pixel queries and measure commands add a query state: the glyph row and width
// memories have registered reads, then the result is formed and registered.
// Configuration writes use cfg_valid, cfg_ready, cfg_index and cfg_data; cfg_ready
// is high only while busy is low, so a write never lands inside a transaction.
// Reset is synchronous: the loader position, the column mask, the ready flag and
// the running text width are cleared, rom_offset reads 0 and space_advance 4.
// The glyph memories are not cleared; queries stay invalid until the font has
// been loaded in full, which is reported in ready_res.
`include "rom_font_glyph_trim_and_measure_defines.svh"

module rom_font_glyph_trim_and_measure (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  output logic                  busy,
  input  fgm_pkg::fgm_in_t      cmd,
  output logic                  done,
  output fgm_pkg::fgm_out_t     result,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [fgm_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [15:0]           cfg_data
);

  fgm_pkg::fgm_cmd_t    ctrl_cmd;
  fgm_pkg::fgm_status_t dp_status;

  assign cfg_ready = !busy;

  // Controller.
  fgm_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .status (dp_status),
    .cmd    (ctrl_cmd),
    .busy   (busy),
    .done   (done)
  );

  // Datapath with the glyph memories.
  fgm_datapath u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cmd_in    (cmd),
    .cmd       (ctrl_cmd),
    .cfg_wr    (cfg_valid && cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .status    (dp_status),
    .result    (result)
  );

  // A result is only ever shown while a transaction is in progress.
  `FGM_ASSERT_SAME(a_done_busy, done, busy, "done raised while not busy")
  // The result strobe lasts exactly one cycle.
  `FGM_ASSERT_NEXT(a_done_pulse, done, !done && !busy, "done held or busy after result")
  // An accepted transaction makes the block busy at once.
  `FGM_ASSERT_NEXT(a_accept_busy, start && !busy, busy, "accepted start did not set busy")
  // The trim pass ends after its last row and goes straight to the result.
  `FGM_ASSERT_NEXT(a_trim_end, ctrl_cmd.trim && dp_status.trim_last, done && !ctrl_cmd.trim,
                   "trim pass did not end on its last row")

endmodule

// ===== bench/glyph_font_scoreboard_pkg.sv =====
`timescale 1ns / 1ps

package glyph_font_scoreboard_pkg;

  import fgm_pkg::*;

  // Tracks the font loader and text measurer, and holds the results that the
  // block owes for every command transaction accepted so far.
  class glyph_font_scoreboard;

    // Register copies.
    logic [15:0] offset_reg;
    logic [3:0]  space_adv_reg;

    // Loader and query state.
    logic [POS_W-1:0] position;
    logic [7:0]       plane_latch;
    logic [7:0]       col_union;
    logic [7:0]       row_buf [GLYPH_ROWS];
    logic [7:0]       glyph_rows [ROW_DEPTH];
    logic [3:0]       glyph_widths [GLYPH_COUNT];
    logic             ready_flag;
    logic [15:0]      running_width;

    fgm_out_t    expected_results [$];
    int unsigned failures;

    function new();
      int i;
      offset_reg    = '0;
      space_adv_reg = SPACE_ADVANCE_RESET;
      position      = '0;
      plane_latch   = '0;
      col_union     = '0;
      ready_flag    = 1'b0;
      running_width = '0;
      failures      = 0;
      for (i = 0; i < GLYPH_ROWS; i++) row_buf[i] = '0;
      for (i = 0; i < ROW_DEPTH; i++) glyph_rows[i] = '0;
      for (i = 0; i < GLYPH_COUNT; i++) glyph_widths[i] = '0;
    endfunction

    function void write_register(logic [CFG_IDX_W-1:0] idx, logic [15:0] value);
      if (idx == CFG_ROM_OFFSET) begin
        offset_reg = value;
      end else if (idx == CFG_SPACE_ADVANCE) begin
        space_adv_reg = value[3:0];
      end
    endfunction

    // Trims the staged glyph flush left and records its width.
    function void close_glyph(int unsigned gi);
      int lo, hi, c, r;
      lo = 8;
      hi = 0;
      for (c = 0; c < 8; c++) begin
        if (col_union[7 - c]) begin
          if (lo == 8) lo = c;
          hi = c;
        end
      end
      if (lo == 8) begin
        glyph_widths[gi] = '0;
        for (r = 0; r < GLYPH_ROWS; r++) glyph_rows[gi * GLYPH_ROWS + r] = '0;
      end else begin
        glyph_widths[gi] = 4'(hi - lo + 1);
        for (r = 0; r < GLYPH_ROWS; r++) glyph_rows[gi * GLYPH_ROWS + r] = row_buf[r] << lo;
      end
      col_union = '0;
      if (gi == GLYPH_COUNT - 1) ready_flag = 1'b1;
    endfunction

    // One ROM byte: skipped before the offset, ignored beyond the table or
    // once the font is complete.
    function void take_rom_byte(logic [7:0] b);
      logic [POS_W-1:0] rel;
      int unsigned      gi;
      logic [3:0]       k;
      logic [7:0]       row;
      if (ready_flag) return;
      if (position >= {1'b0, offset_reg}) begin
        rel = position - {1'b0, offset_reg};
        gi  = 32'(rel[POS_W-1:4]);
        k   = rel[3:0];
        if (gi < GLYPH_COUNT) begin
          if (!k[0]) begin
            plane_latch = b;
          end else begin
            row = plane_latch | b;
            row_buf[k[3:1]] = row;
            col_union = col_union | row;
            if (k == 4'hF) close_glyph(gi);
          end
        end
      end
      if (position != POS_MAX) position = position + 1'b1;
    endfunction

    // Works out the result of an accepted command and queues it.
    function void note_command(fgm_in_t c);
      fgm_out_t      r;
      logic          valid;
      int unsigned   gi;
      logic [16:0]   sum;
      r = '0;
      case (c.operation)
        OP_START: begin
          position    = '0;
          plane_latch = '0;
          col_union   = '0;
          ready_flag  = 1'b0;
        end
        OP_LOAD: begin
          take_rom_byte(c.data_byte);
        end
        default: begin
          valid = ready_flag && c.char_code >= FIRST_CHAR &&
                  c.char_code < FIRST_CHAR + GLYPH_COUNT;
          if (valid) begin
            gi = 32'(c.char_code - FIRST_CHAR);
            r.glyph_width = glyph_widths[gi];
            if (c.x_pos < 8 && c.y_pos < GLYPH_ROWS) begin
              r.pixel = glyph_rows[gi * GLYPH_ROWS + c.y_pos][7 - c.x_pos];
            end
          end
          r.advance = (r.glyph_width == 0) ? space_adv_reg : r.glyph_width + 4'd1;
          if (c.operation == OP_MEASURE) begin
            sum = (c.new_text ? 17'd0 : {1'b0, running_width}) + 17'(r.advance);
            running_width = sum[16] ? 16'hFFFF : sum[15:0];
          end
        end
      endcase
      r.text_width = running_width;
      r.ready_res  = ready_flag;
      expected_results.push_back(r);
    endfunction

    // Compares one result transaction with the oldest expectation.
    function void check_result(fgm_out_t got);
      fgm_out_t want;
      if (expected_results.size() == 0) begin
        failures++;
        if (failures <= 10) begin
          $display("result with nothing expected: pix %0d width %0d adv %0d text %0d ready %0d",
                   got.pixel, got.glyph_width, got.advance, got.text_width, got.ready_res);
        end
        return;
      end
      want = expected_results.pop_front();
      if (got.pixel !== want.pixel || got.glyph_width !== want.glyph_width ||
          got.advance !== want.advance || got.text_width !== want.text_width ||
          got.ready_res !== want.ready_res) begin
        failures++;
        if (failures <= 10) begin
          $display("mismatch: expected pix %0d width %0d adv %0d text %0d ready %0d",
                   want.pixel, want.glyph_width, want.advance, want.text_width,
                   want.ready_res);
          $display("          actual   pix %0d width %0d adv %0d text %0d ready %0d",
                   got.pixel, got.glyph_width, got.advance, got.text_width, got.ready_res);
        end
      end
    endfunction

    function int unsigned pending();
      return expected_results.size();
    endfunction

    function int unsigned error_total();
      return failures + expected_results.size();
    endfunction

  endclass

endpackage

// ===== bench/tb_rom_font_glyph_trim_and_measure.sv =====
`timescale 1ns / 1ps

module tb_rom_font_glyph_trim_and_measure;

  import fgm_pkg::*;
  import glyph_font_scoreboard_pkg::*;

  localparam int STALL_LIMIT = 4000;

  logic                 clk = 1'b0;
  logic                 rst;
  logic                 start;
  logic                 busy;
  fgm_in_t              cmd;
  logic                 done;
  fgm_out_t             result;
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [15:0]          cfg_data;

  glyph_font_scoreboard sb;
  int unsigned          idle_pct;

  rom_font_glyph_trim_and_measure DUT (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .busy      (busy),
    .cmd       (cmd),
    .done      (done),
    .result    (result),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // Clock generation.
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Every result transaction is checked in the cycle in which it is presented.
  always @(posedge clk) begin
    if (!rst && done) sb.check_result(result);
  end

  // The run ends if nothing is accepted for too long.
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk);
      if ((start && !busy) || done || (cfg_valid && cfg_ready)) quiet = 0;
      else quiet++;
    end
    $display("CHECK FAILED");
    $finish;
  end

  // A command with every field random and the operation given.
  function automatic fgm_in_t make_cmd(logic [1:0] op);
    logic [$bits(fgm_in_t)-1:0] raw;
    fgm_in_t                    c;
    raw = $bits(fgm_in_t)'($urandom);
    c = raw;
    c.operation = op;
    return c;
  endfunction

  // Presents one command and returns at the falling edge after it was taken.
  // Start stays high so that a following command can go out back to back.
  task automatic send_command(input fgm_in_t c);
    if ($urandom_range(0, 99) < idle_pct) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 8)) @(negedge clk);
    end
    cmd   <= c;
    start <= 1'b1;
    do @(posedge clk); while (busy);
    sb.note_command(c);
    @(negedge clk);
  endtask

  task automatic send_rom_byte(input logic [7:0] b);
    fgm_in_t c;
    c = make_cmd(OP_LOAD);
    c.data_byte = b;
    send_command(c);
  endtask

  task automatic query(input logic [1:0] op, input logic [7:0] ch, input logic [3:0] x,
                       input logic [3:0] y, input logic nt);
    fgm_in_t c;
    c = make_cmd(op);
    c.char_code = ch;
    c.x_pos     = x;
    c.y_pos     = y;
    c.new_text  = nt;
    send_command(c);
  endtask

  // A query aimed mostly at loaded glyphs and at columns and rows inside them.
  task automatic random_query();
    fgm_in_t c;
    c = make_cmd($urandom_range(0, 1) ? OP_PIXEL : OP_MEASURE);
    if ($urandom_range(0, 4) != 0) begin
      c.char_code = 8'($urandom_range(FIRST_CHAR, FIRST_CHAR + GLYPH_COUNT - 1));
    end
    if ($urandom_range(0, 4) != 0) c.x_pos = 4'($urandom_range(0, 7));
    if ($urandom_range(0, 4) != 0) c.y_pos = 4'($urandom_range(0, 7));
    c.new_text = ($urandom_range(0, 3) == 0);
    send_command(c);
  endtask

  // Drops start and waits until every result has arrived and the block is free.
  task automatic wait_idle();
    start <= 1'b0;
    do @(posedge clk); while (sb.pending() != 0 || busy);
    @(negedge clk);
  endtask

  // One register write transaction, issued while the block is idle.
  task automatic write_register(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    sb.write_register(idx, value);
    @(negedge clk);
    cfg_valid <= 1'b0;
    @(negedge clk);
  endtask

  // Sends the 16 bytes of one glyph. Its set columns lie in a contiguous span,
  // and both span edges appear in some row, so the trimmed width is known.
  // Each row is split at random over the two planes.
  task automatic send_glyph(input bit force_blank);
    logic [7:0] span;
    logic [7:0] plane0;
    logic [7:0] plane1;
    logic [7:0] rows [GLYPH_ROWS];
    int         lo, hi, style, r;
    style = $urandom_range(0, 19);
    if (force_blank || style < 3) begin
      span = 8'h00;
    end else if (style < 6) begin
      span = 8'hFF;
    end else if (style < 9) begin
      span = 8'h80 >> $urandom_range(0, 7);
    end else begin
      lo   = $urandom_range(0, 7);
      hi   = $urandom_range(lo, 7);
      span = (8'hFF >> lo) & (8'hFF << (7 - hi));
    end
    for (r = 0; r < GLYPH_ROWS; r++) rows[r] = 8'($urandom) & span;
    rows[3'($urandom_range(0, 7))] |= span & ~(span >> 1);
    rows[3'($urandom_range(0, 7))] |= span & ~(span << 1);
    if (span == 8'hFF && style < 6) rows[3'($urandom_range(0, 7))] = 8'hFF;
    for (r = 0; r < GLYPH_ROWS; r++) begin
      plane0 = rows[r] & 8'($urandom);
      plane1 = (rows[r] & ~plane0) | (rows[r] & 8'($urandom));
      send_rom_byte(plane0);
      send_rom_byte(plane1);
    end
  endtask

  // A whole font: optional start, the bytes ahead of the offset, then every glyph.
  task automatic load_font(input bit with_start, input bit first_blank);
    int gi;
    if (with_start) send_command(make_cmd(OP_START));
    repeat (sb.offset_reg) send_rom_byte(8'($urandom));
    for (gi = 0; gi < GLYPH_COUNT; gi++) send_glyph(first_blank && gi == 0);
  endtask

  task automatic random_registers();
    logic [15:0] value;
    case ($urandom_range(0, 3))
      0: value = 16'h0000;
      1: value = 16'hFFFF;
      2: value = 16'($urandom_range(0, 64));
      default: value = 16'($urandom);
    endcase
    if ($urandom_range(0, 2) != 0) write_register(CFG_ROM_OFFSET, value);
    value = 16'($urandom);
    case ($urandom_range(0, 3))
      0: value[3:0] = 4'h0;
      1: value[3:0] = 4'hF;
      default: ;
    endcase
    write_register(CFG_SPACE_ADVANCE, value);
  endtask

  initial begin
    int k;
    sb        = new();
    rst       = 1'b1;
    start     = 1'b0;
    cmd       = '0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data  = '0;
    idle_pct  = 9;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    wait_idle();

    // Queries before any font exists read as invalid.
    query(OP_PIXEL, 8'h41, 4'd1, 4'd1, 1'b0);
    query(OP_MEASURE, 8'h41, 4'd0, 4'd0, 1'b1);
    query(OP_MEASURE, 8'h20, 4'd0, 4'd0, 1'b0);

    // First font straight after reset, with no start command; the space glyph
    // is blank. Bytes after the font is complete are ignored.
    load_font(1'b0, 1'b1);
    send_rom_byte(8'hFF);
    send_rom_byte(8'h00);

    // Range edges of the character code and of both coordinates.
    query(OP_PIXEL, 8'h20, 4'd0, 4'd0, 1'b0);
    query(OP_PIXEL, 8'h7F, 4'd7, 4'd7, 1'b0);
    query(OP_PIXEL, 8'h1F, 4'd3, 4'd3, 1'b0);
    query(OP_PIXEL, 8'h80, 4'd0, 4'd0, 1'b0);
    query(OP_PIXEL, 8'hFF, 4'd15, 4'd15, 1'b1);
    query(OP_PIXEL, 8'h00, 4'd0, 4'd0, 1'b0);
    query(OP_PIXEL, 8'h41, 4'd8, 4'd3, 1'b0);
    query(OP_PIXEL, 8'h41, 4'd3, 4'd8, 1'b0);
    query(OP_MEASURE, 8'h41, 4'd0, 4'd0, 1'b1);
    query(OP_MEASURE, 8'h20, 4'd2, 4'd2, 1'b0);
    query(OP_MEASURE, 8'h7F, 4'd15, 4'd0, 1'b0);
    query(OP_MEASURE, 8'hFF, 4'd0, 4'd15, 1'b0);

    // A long burst of queries with no idle cycles, then shorter bursts with
    // register changes and stray load bytes, which the complete font ignores.
    idle_pct = 0;
    repeat (150) random_query();
    idle_pct = 9;
    for (k = 0; k < 5; k++) begin
      wait_idle();
      random_registers();
      repeat ($urandom_range(0, 4)) send_rom_byte(8'($urandom));
      repeat ($urandom_range(20, 40)) random_query();
    end

    // A start command drops the ready flag but keeps the running width.
    send_command(make_cmd(OP_START));
    query(OP_MEASURE, 8'h41, 4'd1, 4'd1, 1'b0);
    query(OP_PIXEL, 8'h41, 4'd1, 4'd1, 1'b0);

    // Broken loads with the offset moved part way through, mixed with random
    // commands of every kind.
    for (k = 0; k < 4; k++) begin
      if ($urandom_range(0, 1) != 0) send_command(make_cmd(OP_START));
      repeat ($urandom_range(1, 40)) send_rom_byte(8'($urandom));
      wait_idle();
      write_register(CFG_ROM_OFFSET, 16'($urandom_range(0, 40)));
      repeat ($urandom_range(1, 20)) send_rom_byte(8'($urandom));
      repeat ($urandom_range(10, 30)) send_command(make_cmd(2'($urandom)));
    end

    // Drain, allow the block to settle, then report.
    wait_idle();
    repeat (16) @(posedge clk);
    if (sb.error_total() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+sv
sv/fgm_pkg.sv
sv/fgm_ctrl.sv
sv/fgm_datapath.sv
sv/rom_font_glyph_trim_and_measure.sv
bench/glyph_font_scoreboard_pkg.sv
bench/tb_rom_font_glyph_trim_and_measure.sv
